[hdl/sps_pkg.sv]
`timescale 1ns / 1ps

package sps_pkg;

  localparam int VALUE_BITS_DEF       = 20;
  localparam int SEGMENT_LENGTH_DEF   = 64;
  localparam int BASE_LIMIT_DEF       = 1024;
  localparam int BASE_PRIME_COUNT_DEF = 172;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQRT,
    ST_BINIT,
    ST_BCHK,
    ST_BTEST,
    ST_BMARK,
    ST_CRD,
    ST_CTEST,
    ST_SINIT,
    ST_PRD,
    ST_PLD,
    ST_DIV,
    ST_PSTART,
    ST_PMARK,
    ST_ORD,
    ST_OLD,
    ST_OHOLD
  } state_t;

endpackage

[hdl/sps_ram.sv]
`timescale 1ns / 1ps

module sps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

[hdl/segmented_prime_sieve.sv]
`timescale 1ns / 1ps
// channel | dir | tdata                                  | tuser                  | tlast
// s_      | in  | range_low, range_high                  | -                      | -
// m_      | out | number                                 | is_prime, range_error  | last
//
// one request at a time; a bad range gives its single result in the cycle after the beat
// the pace of a good range is set by the single read and write port of each mark memory
// rst is synchronous and clears the sequencer; memories are rewritten before use
// a stalled result holds the sequencer in place

module segmented_prime_sieve #(
  parameter int VALUE_BITS       = sps_pkg::VALUE_BITS_DEF,
  parameter int SEGMENT_LENGTH   = sps_pkg::SEGMENT_LENGTH_DEF,
  parameter int BASE_LIMIT       = sps_pkg::BASE_LIMIT_DEF,
  parameter int BASE_PRIME_COUNT = sps_pkg::BASE_PRIME_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // range_low, range_high
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]     m_tdata,  // number
  output logic [1:0]                          m_tuser,  // is_prime, range_error
  output logic                                m_tlast
);

  localparam int VB  = VALUE_BITS;
  localparam int OW  = ((VALUE_BITS+7)/8)*8;
  localparam int PW  = $clog2(BASE_LIMIT+1);
  localparam int SW  = $clog2(SEGMENT_LENGTH);
  localparam int RB  = (VALUE_BITS+1)/2;
  localparam int RBW = (RB > 1) ? $clog2(RB) : 1;
  localparam int DW  = $clog2(VALUE_BITS);
  localparam int KW  = $clog2(BASE_PRIME_COUNT+1);
  localparam int LW  = $clog2(BASE_PRIME_COUNT);
  localparam int CW  = (2*PW+2 > VB+2) ? 2*PW+2 : VB+2;

  sps_pkg::state_t state, state_next;

  logic [VB-1:0]  low, high;
  logic [SW-1:0]  diff;
  logic [RB-1:0]  root;
  logic [RBW-1:0] sb;
  logic [PW-1:0]  limit;
  logic [PW-1:0]  bi;
  logic [PW:0]    bp;
  logic [PW:0]    mi;
  logic [PW:0]    q;
  logic [KW-1:0]  cnt;
  logic [KW-1:0]  k;
  logic [SW-1:0]  j;
  logic [PW-1:0]  p;
  logic [CW-1:0]  pp;
  logic [PW:0]    rem;
  logic [DW-1:0]  dv;
  logic [CW-1:0]  i_s;
  logic           out_valid;
  logic [VB-1:0]  out_number;
  logic           out_prime, out_last, out_err;

  logic           bm_we, bm_wd, bm_re, bm_rd;
  logic [PW-1:0]  bm_wa, bm_ra;
  logic           pl_we, pl_re;
  logic [LW-1:0]  pl_wa, pl_ra;
  logic [PW-1:0]  pl_wd, pl_rd;
  logic           sg_we, sg_wd, sg_re, sg_rd;
  logic [SW-1:0]  sg_wa, sg_ra;

  logic [VB-1:0]  in_low, in_high;
  logic           in_err;
  logic [RB-1:0]  trial, root_new;
  logic [PW-1:0]  limit_c;
  logic [PW:0]    rem_sh;
  logic [CW-1:0]  first_c, start_c;
  logic [VB-1:0]  num_c;

  assign in_low  = s_tdata[VB-1:0];
  assign in_high = s_tdata[2*VB-1:VB];
  assign in_err  = (in_high < in_low) ||
                   ((VB+1)'(in_high) - (VB+1)'(in_low) > (VB+1)'(SEGMENT_LENGTH-1));

  assign trial    = root | (RB'(1) << sb);
  assign root_new = ((2*RB)'(trial) * (2*RB)'(trial) <= (2*RB)'(high)) ? trial : root;
  assign limit_c  = (CW'(root_new) + CW'(1) > CW'(BASE_LIMIT)) ? PW'(BASE_LIMIT)
                                                              : PW'(root_new) + PW'(1);

  assign rem_sh  = {rem[PW-1:0], low[dv]};
  assign first_c = (rem == '0) ? CW'(low) : CW'(low) + CW'(p) - CW'(rem);
  assign start_c = (first_c > pp) ? first_c : pp;
  assign num_c   = low + VB'(j);

  assign s_tready = (state == sps_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = OW'(out_number);
  assign m_tuser  = {out_err, out_prime};
  assign m_tlast  = out_last;

  always_comb begin
    state_next = state;
    case (state)
      sps_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = in_err ? sps_pkg::ST_OHOLD : sps_pkg::ST_SQRT;
        end
      end
      sps_pkg::ST_SQRT: begin
        if (sb == '0) state_next = sps_pkg::ST_BINIT;
      end
      sps_pkg::ST_BINIT: begin
        if (bi == limit) state_next = sps_pkg::ST_BCHK;
      end
      sps_pkg::ST_BCHK: begin
        if (CW'(bp) * CW'(bp) > CW'(limit)) state_next = sps_pkg::ST_CRD;
        else state_next = sps_pkg::ST_BTEST;
      end
      sps_pkg::ST_BTEST: begin
        state_next = bm_rd ? sps_pkg::ST_BMARK : sps_pkg::ST_BCHK;
      end
      sps_pkg::ST_BMARK: begin
        if (mi > (PW+1)'(limit)) state_next = sps_pkg::ST_BCHK;
      end
      sps_pkg::ST_CRD: begin
        state_next = (q > (PW+1)'(limit)) ? sps_pkg::ST_SINIT : sps_pkg::ST_CTEST;
      end
      sps_pkg::ST_CTEST:  state_next = sps_pkg::ST_CRD;
      sps_pkg::ST_SINIT: begin
        if (j == diff) state_next = sps_pkg::ST_PRD;
      end
      sps_pkg::ST_PRD: begin
        state_next = (k == cnt) ? sps_pkg::ST_ORD : sps_pkg::ST_PLD;
      end
      sps_pkg::ST_PLD:    state_next = sps_pkg::ST_DIV;
      sps_pkg::ST_DIV: begin
        if (dv == '0) state_next = sps_pkg::ST_PSTART;
      end
      sps_pkg::ST_PSTART: state_next = sps_pkg::ST_PMARK;
      sps_pkg::ST_PMARK: begin
        if (i_s > CW'(high)) state_next = sps_pkg::ST_PRD;
      end
      sps_pkg::ST_ORD:    state_next = sps_pkg::ST_OLD;
      sps_pkg::ST_OLD:    state_next = sps_pkg::ST_OHOLD;
      sps_pkg::ST_OHOLD: begin
        if (m_tready) state_next = out_last ? sps_pkg::ST_IDLE : sps_pkg::ST_ORD;
      end
      default:            state_next = sps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    bm_we = 1'b0;
    bm_wa = bi;
    bm_wd = 1'b1;
    bm_re = 1'b0;
    bm_ra = bp[PW-1:0];
    pl_we = 1'b0;
    pl_wa = LW'(cnt);
    pl_wd = q[PW-1:0];
    pl_re = 1'b0;
    pl_ra = LW'(k);
    sg_we = 1'b0;
    sg_wa = j;
    sg_wd = 1'b1;
    sg_re = 1'b0;
    sg_ra = j;
    case (state)
      sps_pkg::ST_BINIT: bm_we = 1'b1;
      sps_pkg::ST_BCHK:  bm_re = 1'b1;
      sps_pkg::ST_BMARK: begin
        bm_we = (mi <= (PW+1)'(limit));
        bm_wa = mi[PW-1:0];
        bm_wd = 1'b0;
      end
      sps_pkg::ST_CRD: begin
        bm_re = 1'b1;
        bm_ra = q[PW-1:0];
      end
      sps_pkg::ST_CTEST: pl_we = bm_rd && (cnt < KW'(BASE_PRIME_COUNT));
      sps_pkg::ST_SINIT: sg_we = 1'b1;
      sps_pkg::ST_PRD:   pl_re = (k != cnt);
      sps_pkg::ST_PMARK: begin
        sg_we = (i_s <= CW'(high));
        sg_wa = SW'(i_s - CW'(low));
        sg_wd = 1'b0;
      end
      sps_pkg::ST_ORD:   sg_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sps_pkg::ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      case (state)
        sps_pkg::ST_IDLE: begin
          low  <= in_low;
          high <= in_high;
          diff <= SW'(in_high - in_low);
          root <= '0;
          sb   <= RBW'(RB-1);
          bi   <= '0;
          j    <= '0;
          if (s_tvalid && in_err) begin
            out_valid  <= 1'b1;
            out_number <= in_low;
            out_prime  <= 1'b0;
            out_last   <= 1'b1;
            out_err    <= 1'b1;
          end
        end
        sps_pkg::ST_SQRT: begin
          root <= root_new;
          sb   <= sb - RBW'(1);
          if (sb == '0) begin
            limit <= limit_c;
            bp    <= (PW+1)'(2);
          end
        end
        sps_pkg::ST_BINIT: bi <= bi + PW'(1);
        sps_pkg::ST_BCHK: begin
          q   <= (PW+1)'(2);
          cnt <= '0;
        end
        sps_pkg::ST_BTEST: begin
          if (bm_rd) mi <= (PW+1)'(CW'(bp) * CW'(bp));
          else bp <= bp + (PW+1)'(1);
        end
        sps_pkg::ST_BMARK: begin
          if (mi > (PW+1)'(limit)) bp <= bp + (PW+1)'(1);
          else mi <= mi + bp;
        end
        sps_pkg::ST_CTEST: begin
          if (pl_we) cnt <= cnt + KW'(1);
          q <= q + (PW+1)'(1);
        end
        sps_pkg::ST_SINIT: begin
          j <= j + SW'(1);
          k <= '0;
        end
        sps_pkg::ST_PRD: j <= '0;
        sps_pkg::ST_PLD: begin
          p   <= pl_rd;
          pp  <= CW'(pl_rd) * CW'(pl_rd);
          rem <= '0;
          dv  <= DW'(VB-1);
        end
        sps_pkg::ST_DIV: begin
          rem <= (rem_sh >= (PW+1)'(p)) ? rem_sh - (PW+1)'(p) : rem_sh;
          dv  <= dv - DW'(1);
        end
        sps_pkg::ST_PSTART: i_s <= start_c;
        sps_pkg::ST_PMARK: begin
          if (i_s > CW'(high)) k <= k + KW'(1);
          else i_s <= i_s + CW'(p);
        end
        sps_pkg::ST_OLD: begin
          out_valid  <= 1'b1;
          out_number <= num_c;
          out_prime  <= sg_rd && (num_c >= VB'(2));
          out_last   <= (j == diff);
          out_err    <= 1'b0;
        end
        sps_pkg::ST_OHOLD: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            j         <= j + SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  sps_ram #(.WIDTH(1), .DEPTH(BASE_LIMIT+1)) u_base_marks (
    .clk(clk), .we(bm_we), .wa(bm_wa), .wd(bm_wd), .re(bm_re), .ra(bm_ra), .rd(bm_rd)
  );

  sps_ram #(.WIDTH(PW), .DEPTH(BASE_PRIME_COUNT)) u_base_primes (
    .clk(clk), .we(pl_we), .wa(pl_wa), .wd(pl_wd), .re(pl_re), .ra(pl_ra), .rd(pl_rd)
  );

  sps_ram #(.WIDTH(1), .DEPTH(SEGMENT_LENGTH)) u_segment_marks (
    .clk(clk), .we(sg_we), .wa(sg_wa), .wd(sg_wd), .re(sg_re), .ra(sg_ra), .rd(sg_rd)
  );

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("request taken while result pending");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast) else $error("range error not last");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= KW'(BASE_PRIME_COUNT)) else $error("base prime count overflow");

  a_seg_write: assert property (@(posedge clk) disable iff (rst)
    state == sps_pkg::ST_PMARK && i_s <= CW'(high) |-> i_s >= CW'(low))
    else $error("segment mark below range");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  localparam int VB = sps_pkg::VALUE_BITS_DEF;
  localparam int SEG = sps_pkg::SEGMENT_LENGTH_DEF;
  localparam int BLIM = sps_pkg::BASE_LIMIT_DEF;

  typedef struct packed {
    logic [VB-1:0] low;
    logic [VB-1:0] high;
  } range_t;

  typedef struct packed {
    logic [VB-1:0] number;
    logic          is_prime;
    logic          last;
    logic          range_error;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  segmented_prime_sieve u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  range_t   pending_ranges[$];
  verdict_t expected_verdicts[$];
  int       errors = 0;
  int       beats_in = 0;
  int       beats_out = 0;
  int       bad_ranges = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_cycles = 0;
  bit       pause_send = 1'b0;
  bit       base_mark[0:BLIM];
  int       base_primes[$];

  function automatic longint isqrt(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 32'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic queue_range(range_t r);
    pending_ranges = {pending_ranges, r};
  endtask

  task automatic predict_segment(range_t r);
    longint lo, hi, n, lim, p, i, first, start;
    bit seg[0:SEG-1];
    verdict_t v;
    lo = r.low;
    hi = r.high;
    if (hi < lo || hi - lo + 1 > SEG) begin
      v.number = r.low;
      v.is_prime = 1'b0;
      v.last = 1'b1;
      v.range_error = 1'b1;
      expected_verdicts = {expected_verdicts, v};
      return;
    end
    n = hi - lo + 1;
    lim = isqrt(hi) + 1;
    if (lim > BLIM) lim = BLIM;
    for (i = 0; i <= lim; i++) base_mark[i] = 1'b1;
    for (p = 2; p * p <= lim; p++)
      if (base_mark[p])
        for (i = p * p; i <= lim; i += p) base_mark[i] = 1'b0;
    base_primes.delete();
    for (p = 2; p <= lim; p++)
      if (base_mark[p] && base_primes.size() < sps_pkg::BASE_PRIME_COUNT_DEF)
        base_primes = {base_primes, int'(p)};
    for (i = 0; i < n; i++) seg[i] = 1'b1;
    foreach (base_primes[k]) begin
      p = base_primes[k];
      first = (lo + p - 1) / p * p;
      start = p * p;
      if (first > start) start = first;
      for (i = start; i <= hi; i += p) seg[i - lo] = 1'b0;
    end
    for (i = 0; i < n; i++) begin
      v.number = VB'(lo + i);
      v.is_prime = seg[i] && (lo + i >= 2);
      v.last = (i + 1 == n);
      v.range_error = 1'b0;
      expected_verdicts = {expected_verdicts, v};
    end
  endtask

  function automatic range_t pick_range();
    range_t r;
    int len;
    int mode;
    mode = $urandom_range(0, 9);
    len = (mode < 6) ? $urandom_range(1, 12) : $urandom_range(1, SEG);
    case (mode % 5)
      0: r.low = VB'($urandom_range(0, 40));
      default: r.low = VB'($urandom);
    endcase
    if (mode == 9) begin
      r.high = VB'($urandom);
    end else if (32'(r.low) + len - 1 > (1 << VB) - 1) begin
      r.high = '1;
    end else begin
      r.high = r.low + VB'(len - 1);
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_tready) begin
    end else begin
      if (s_tvalid) beats_in <= beats_in + 1;
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pause_send || pending_ranges.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        range_t r;
        r = pending_ranges.pop_front();
        predict_segment(r);
        if (r.high < r.low || r.high - r.low + 1 > SEG) bad_ranges <= bad_ranges + 1;
        s_tdata <= {r.high, r.low};
        s_tvalid <= 1'b1;
        send_gap <= $urandom_range(0, 3);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        verdict_t v;
        beats_out <= beats_out + 1;
        if (expected_verdicts.size() == 0) begin
          $display("%0t unexpected beat number=%0d", $time, m_tdata[VB-1:0]);
          errors <= errors + 1;
        end else begin
          v = expected_verdicts.pop_front();
          if (m_tdata[VB-1:0] !== v.number || m_tuser[0] !== v.is_prime ||
              m_tlast !== v.last || m_tuser[1] !== v.range_error) begin
            $display("%0t mismatch expected num=%0d p=%0b l=%0b e=%0b actual num=%0d p=%0b l=%0b e=%0b",
                     $time, v.number, v.is_prime, v.last, v.range_error,
                     m_tdata[VB-1:0], m_tuser[0], m_tlast, m_tuser[1]);
            errors <= errors + 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else if (recv_gap > 0) begin
        m_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (m_tready && m_tvalid) begin
        recv_gap = $urandom_range(0, 3);
        m_tready <= (recv_gap == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    range_t r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    r.low = 0;       r.high = 10;      queue_range(r);
    r.low = 0;       r.high = 0;       queue_range(r);
    r.low = 1;       r.high = 2;       queue_range(r);
    r.low = 2;       r.high = 65;      queue_range(r);
    r.low = 2;       r.high = 66;      queue_range(r);
    r.low = 10;      r.high = 9;       queue_range(r);
    r.low = '1;      r.high = 0;       queue_range(r);
    r.low = 20'hFFFC1; r.high = '1;    queue_range(r);
    r.low = '1;      r.high = '1;      queue_range(r);
    r.low = 0;       r.high = '1;      queue_range(r);
    r.low = 1046520; r.high = 1046560; queue_range(r);
    r.low = 961;     r.high = 1000;    queue_range(r);
    r.low = 20'h55555; r.high = 20'h55590; queue_range(r);
    r.low = 20'hAAAAA; r.high = 20'hAAAAF; queue_range(r);
    r.low = 3;       r.high = 3;       queue_range(r);
    for (int i = 0; i < 60; i++) queue_range(pick_range());
    wait (pending_ranges.size() == 0);
    // long receiver hold while requests keep coming
    @(posedge clk);
    hold_cycles <= 3000;
    for (int i = 0; i < 10; i++) queue_range(pick_range());
    wait (pending_ranges.size() == 0);
    @(posedge clk);
    pause_send <= 1'b1;
    wait (expected_verdicts.size() == 0 && !s_tvalid);
    @(posedge clk);
    pause_send <= 1'b0;
    for (int i = 0; i < 60; i++) queue_range(pick_range());
    wait (pending_ranges.size() == 0 && !s_tvalid);
    wait (expected_verdicts.size() == 0);
    repeat (50) @(posedge clk);
    $display("covered %0d requests (%0d bad ranges), %0d result beats checked",
             beats_in, bad_ranges, beats_out);
    if (errors == 0 && expected_verdicts.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
